// ----- src/drld_pkg.sv -----
package drld_pkg;

  // largest byte count a header nibble may ask for
  localparam int unsigned MaxFieldBytes = 8;
  // byte lanes of a 64-bit field
  localparam int unsigned FieldLanes = 8;
  localparam int unsigned LaneW = $clog2(FieldLanes);
  localparam int unsigned FieldW = 8 * FieldLanes;
  // entries between parser and executor
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    CMD_RUN,
    CMD_END,
    CMD_BAD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [FieldW-1:0]   run_length;
    logic [FieldW-1:0]   delta;
  } cmd_t;

endpackage

// ----- src/drld_byte_if.sv -----
interface drld_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// ----- src/drld_run_if.sv -----
interface drld_run_if;
  logic        valid;
  logic        ready;
  logic [63:0] run_length;
  logic [63:0] start_cluster;
  logic        end_of_list;
  logic        bad_header;

  modport source (
    output valid, output run_length, output start_cluster,
    output end_of_list, output bad_header, input ready
  );
  modport sink (
    input valid, input run_length, input start_cluster,
    input end_of_list, input bad_header, output ready
  );
endinterface

// ----- src/drld_parse.sv -----
module drld_parse #(
  parameter int unsigned MAX_FIELD_BYTES = drld_pkg::MaxFieldBytes
) (
  input  logic          clk,
  input  logic          rst,
  drld_byte_if.sink     bytes,
  input  logic          full,
  output logic          push,
  output drld_pkg::cmd_t push_cmd
);
  import drld_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_FIELD_BYTES + 1);
  localparam int unsigned PosW = (MAX_FIELD_BYTES > 1) ? $clog2(MAX_FIELD_BYTES) : 1;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_LENGTH = 3'b010,
    PH_OFFSET = 3'b100
  } phase_t;

  phase_t            phase, phase_next;
  logic [CntW-1:0]   len_left, len_left_next;
  logic [CntW-1:0]   off_left, off_left_next;
  logic [PosW-1:0]   pos, pos_next;
  logic [FieldW-1:0] len_acc, len_acc_next;
  logic [FieldW-1:0] dlt_acc, dlt_acc_next;
  logic [FieldW-1:0] len_wr, dlt_wr;
  logic [3:0]        hdr_lc, hdr_oc;
  logic              take;
  logic              off_last;

  assign bytes.ready = !full;
  assign take = bytes.valid && !full;
  assign hdr_lc = bytes.data_byte[3:0];
  assign hdr_oc = bytes.data_byte[7:4];
  assign off_last = (off_left == CntW'(1));

  // byte lane write; the last offset byte also sign-fills the lanes above it
  always_comb begin
    for (int i = 0; i < FieldLanes; i++) begin
      if (LaneW'(i) == LaneW'(pos)) begin
        len_wr[i*8 +: 8] = bytes.data_byte;
        dlt_wr[i*8 +: 8] = bytes.data_byte;
      end else begin
        len_wr[i*8 +: 8] = len_acc[i*8 +: 8];
        if (off_last && (LaneW'(i) > LaneW'(pos))) begin
          dlt_wr[i*8 +: 8] = {8{bytes.data_byte[7]}};
        end else begin
          dlt_wr[i*8 +: 8] = dlt_acc[i*8 +: 8];
        end
      end
    end
  end

  always_comb begin
    phase_next    = phase;
    len_left_next = len_left;
    off_left_next = off_left;
    pos_next      = pos;
    len_acc_next  = len_acc;
    dlt_acc_next  = dlt_acc;
    push          = 1'b0;
    push_cmd.kind       = CMD_RUN;
    push_cmd.run_length = len_wr;
    push_cmd.delta      = '0;
    if (take) begin
      unique case (phase)
        PH_LENGTH: begin
          len_acc_next  = len_wr;
          pos_next      = pos + PosW'(1);
          len_left_next = len_left - CntW'(1);
          if (len_left == CntW'(1)) begin
            if (off_left == '0) begin
              push       = 1'b1;
              phase_next = PH_HEADER;
            end else begin
              phase_next = PH_OFFSET;
              pos_next   = '0;
            end
          end
        end
        PH_OFFSET: begin
          dlt_acc_next  = dlt_wr;
          pos_next      = pos + PosW'(1);
          off_left_next = off_left - CntW'(1);
          push_cmd.run_length = len_acc;
          push_cmd.delta      = dlt_wr;
          if (off_last) begin
            push       = 1'b1;
            phase_next = PH_HEADER;
          end
        end
        default: begin
          // header byte; an unused phase code lands here too
          phase_next = PH_HEADER;
          push_cmd.run_length = '0;
          if (bytes.data_byte == 8'h00) begin
            push          = 1'b1;
            push_cmd.kind = CMD_END;
          end else if (hdr_lc > 4'(MAX_FIELD_BYTES) || hdr_oc > 4'(MAX_FIELD_BYTES)) begin
            push          = 1'b1;
            push_cmd.kind = CMD_BAD;
          end else begin
            len_left_next = CntW'(hdr_lc);
            off_left_next = CntW'(hdr_oc);
            pos_next      = '0;
            len_acc_next  = '0;
            dlt_acc_next  = '0;
            phase_next    = (hdr_lc != 4'd0) ? PH_LENGTH : PH_OFFSET;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HEADER;
      len_left <= '0;
      off_left <= '0;
      pos      <= '0;
    end else begin
      phase    <= phase_next;
      len_left <= len_left_next;
      off_left <= off_left_next;
      pos      <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    len_acc <= len_acc_next;
    dlt_acc <= dlt_acc_next;
  end

endmodule

// ----- src/drld_queue.sv -----
module drld_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  drld_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output drld_pkg::cmd_t head
);
  import drld_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            entry [QueueDepth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign full  = (count == CntW'(QueueDepth));
  assign empty = (count == '0);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

// ----- src/drld_exec.sv -----
module drld_exec (
  input  logic           clk,
  input  logic           rst,
  input  logic           empty,
  input  drld_pkg::cmd_t head,
  output logic           pop,
  drld_run_if.source     runs
);
  import drld_pkg::*;

  logic [FieldW-1:0] prev_cluster;
  logic [FieldW-1:0] start_sum;
  logic              out_valid;
  logic [FieldW-1:0] out_length, out_start;
  logic              out_end, out_bad;

  assign start_sum = prev_cluster + head.delta;
  // output register frees up when empty or when its request is taken
  assign pop = !empty && (!out_valid || runs.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      prev_cluster <= '0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
        unique case (head.kind)
          CMD_RUN: prev_cluster <= start_sum;
          CMD_END: prev_cluster <= '0;
          default: prev_cluster <= prev_cluster;
        endcase
      end else if (runs.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      unique case (head.kind)
        CMD_RUN: begin
          out_length <= head.run_length;
          out_start  <= start_sum;
          out_end    <= 1'b0;
          out_bad    <= 1'b0;
        end
        CMD_END: begin
          out_length <= '0;
          out_start  <= '0;
          out_end    <= 1'b1;
          out_bad    <= 1'b0;
        end
        default: begin
          out_length <= '0;
          out_start  <= '0;
          out_end    <= 1'b0;
          out_bad    <= 1'b1;
        end
      endcase
    end
  end

  assign runs.valid         = out_valid;
  assign runs.run_length    = out_length;
  assign runs.start_cluster = out_start;
  assign runs.end_of_list   = out_end;
  assign runs.bad_header    = out_bad;

endmodule

// ----- src/data_run_list_decoder.sv -----
// Run-list decoder: takes the bytes of a mapping-pairs run list, one byte per
// request on bytes, and returns one request on runs for each complete run
// (run_length and absolute start_cluster, with a sign-extended delta), for a
// zero header (end_of_list, which also restarts the cluster base at zero) and
// for a header nibble above MAX_FIELD_BYTES (bad_header). A byte is taken every
// cycle while the two-entry queue between the byte parser and the run
// executor has room; each run costs the executor one 64-bit add, so runs leave
// at up to one per cycle while runs is ready. A result passes from the byte
// completing it through a queue entry into an output register that holds it
// until taken.
module data_run_list_decoder #(
  parameter int unsigned MAX_FIELD_BYTES = drld_pkg::MaxFieldBytes
) (
  input  logic       clk,
  input  logic       rst,
  drld_byte_if.sink  bytes,
  drld_run_if.source runs
);
  import drld_pkg::*;

  logic push, pop, full, empty;
  cmd_t push_cmd, head;

  drld_parse #(
    .MAX_FIELD_BYTES(MAX_FIELD_BYTES)
  ) u_parse (
    .clk      (clk),
    .rst      (rst),
    .bytes    (bytes),
    .full     (full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  drld_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  drld_exec u_exec (
    .clk   (clk),
    .rst   (rst),
    .empty (empty),
    .head  (head),
    .pop   (pop),
    .runs  (runs)
  );

endmodule

// ----- bench/data_run_list_decoder_tb.sv -----
module data_run_list_decoder_tb;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned TailCycles = 20;
  localparam int unsigned PhaseBytes = 275;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_LENGTH = 3'b010,
    PH_OFFSET = 3'b100
  } parse_phase_t;

  typedef struct packed {
    logic [63:0] run_length;
    logic [63:0] start_cluster;
    logic        end_of_list;
    logic        bad_header;
  } run_t;

  class run_list_tracker;
    run_t         expected_runs[$];
    int           mismatches;
    parse_phase_t phase;
    logic [3:0]   len_left;
    logic [3:0]   off_left;
    logic [3:0]   off_count;
    logic [2:0]   lane;
    logic [63:0]  len_acc;
    logic [63:0]  delta_acc;
    logic [63:0]  prev_cluster;

    function new();
      mismatches = 0;
      phase = PH_HEADER;
      len_left = '0;
      off_left = '0;
      off_count = '0;
      lane = '0;
      len_acc = '0;
      delta_acc = '0;
      prev_cluster = '0;
    endfunction

    function void report(string what, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t mismatch %s: expected %h got %h", $time, what, want, got);
      end
    endfunction

    function int pending();
      return expected_runs.size();
    endfunction

    // last byte of a run: sign-extend the delta and move the cluster base
    function void close_run();
      logic [63:0] delta;
      run_t        r;
      delta = delta_acc;
      if (off_count > 0 && off_count < 8 && delta[8 * off_count - 1]) begin
        delta = delta | ({64{1'b1}} << (8 * off_count));
      end
      prev_cluster = prev_cluster + delta;
      r = '{run_length: len_acc, start_cluster: prev_cluster,
            end_of_list: 1'b0, bad_header: 1'b0};
      expected_runs.push_back(r);
      phase = PH_HEADER;
      lane = '0;
    endfunction

    function void note_byte(logic [7:0] b);
      logic [63:0] wide;
      logic [3:0]  lc;
      logic [3:0]  oc;
      run_t        r;
      wide = {56'b0, b} << (8 * lane);
      lc = b[3:0];
      oc = b[7:4];
      case (phase)
        PH_LENGTH: begin
          len_acc = len_acc | wide;
          lane = lane + 3'd1;
          len_left = len_left - 4'd1;
          if (len_left == 0) begin
            if (off_left == 0) begin
              close_run();
            end else begin
              phase = PH_OFFSET;
              lane = '0;
            end
          end
        end
        PH_OFFSET: begin
          delta_acc = delta_acc | wide;
          lane = lane + 3'd1;
          off_left = off_left - 4'd1;
          if (off_left == 0) close_run();
        end
        default: begin
          phase = PH_HEADER;
          if (b == 8'h00) begin
            prev_cluster = '0;
            r = '{run_length: '0, start_cluster: '0, end_of_list: 1'b1, bad_header: 1'b0};
            expected_runs.push_back(r);
          end else if (lc > drld_pkg::MaxFieldBytes || oc > drld_pkg::MaxFieldBytes) begin
            r = '{run_length: '0, start_cluster: '0, end_of_list: 1'b0, bad_header: 1'b1};
            expected_runs.push_back(r);
          end else begin
            len_left = lc;
            off_left = oc;
            off_count = oc;
            lane = '0;
            len_acc = '0;
            delta_acc = '0;
            phase = (lc != 0) ? PH_LENGTH : PH_OFFSET;
          end
        end
      endcase
    endfunction

    function void check_run(run_t got);
      run_t want;
      if (expected_runs.size() == 0) begin
        report("unexpected run, start_cluster", '0, got.start_cluster);
        return;
      end
      want = expected_runs.pop_front();
      if (got.run_length !== want.run_length)
        report("run_length", want.run_length, got.run_length);
      if (got.start_cluster !== want.start_cluster)
        report("start_cluster", want.start_cluster, got.start_cluster);
      if (got.end_of_list !== want.end_of_list)
        report("end_of_list", 64'(want.end_of_list), 64'(got.end_of_list));
      if (got.bad_header !== want.bad_header)
        report("bad_header", 64'(want.bad_header), 64'(got.bad_header));
    endfunction

    function int leftover_check();
      while (expected_runs.size() != 0) begin
        report("missing run, start_cluster", expected_runs[0].start_cluster, '0);
        void'(expected_runs.pop_front());
      end
      return mismatches;
    endfunction
  endclass

  logic clk;
  logic rst;

  drld_byte_if bytes_ch();
  drld_run_if  runs_ch();

  data_run_list_decoder dut (
    .clk  (clk),
    .rst  (rst),
    .bytes(bytes_ch),
    .runs (runs_ch)
  );

  run_list_tracker tracker;
  int unsigned     send_idle_pct;
  int unsigned     stall_pct;
  int unsigned     bytes_sent;
  int unsigned     idle_cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result side: random stalls and checking
  always @(posedge clk) begin
    runs_ch.ready <= ($urandom_range(99) >= stall_pct);
    if (!rst && runs_ch.valid && runs_ch.ready) begin
      tracker.check_run('{run_length: runs_ch.run_length,
                          start_cluster: runs_ch.start_cluster,
                          end_of_list: runs_ch.end_of_list,
                          bad_header: runs_ch.bad_header});
    end
  end

  // watchdog on cycles with no request moving on either side
  always @(posedge clk) begin
    if (rst || (bytes_ch.valid && bytes_ch.ready) || (runs_ch.valid && runs_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("data_run_list_decoder_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      bytes_ch.valid <= 1'b0;
      @(posedge clk);
    end
    bytes_ch.valid <= 1'b1;
    bytes_ch.data_byte <= b;
    @(posedge clk);
    while (!bytes_ch.ready) @(posedge clk);
    tracker.note_byte(b);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    bytes_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_random_entry();
    int unsigned pick;
    logic [3:0]  lc;
    logic [3:0]  oc;
    pick = $urandom_range(99);
    if (pick < 6) begin
      send_byte(8'h00);
    end else if (pick < 11) begin
      lc = 4'($urandom_range(15));
      oc = 4'($urandom_range(15, 9));
      if ($urandom_range(1)) send_byte({oc, lc});
      else send_byte({lc, oc});
    end else if (pick < 16) begin
      // stray byte: header or data depending on where the parser is
      send_byte(8'($urandom_range(255)));
    end else begin
      lc = 4'($urandom_range(8));
      oc = 4'($urandom_range(8));
      if (lc == 0 && oc == 0) lc = 4'd1;
      send_byte({oc, lc});
      repeat (lc) send_byte(pick_byte());
      repeat (oc) send_byte(pick_byte());
    end
  endtask

  initial begin
    logic [7:0] directed_bytes[$];
    int unsigned target;

    tracker = new();
    send_idle_pct = 0;
    stall_pct = 0;
    bytes_sent = 0;
    rst <= 1'b1;
    bytes_ch.valid <= 1'b0;
    bytes_ch.data_byte <= 8'h00;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    directed_bytes = '{
      8'h00,                        // end of list straight after reset
      8'h11, 8'hFF, 8'h80,          // one-byte negative delta
      8'h01, 8'h05,                 // sparse run, no offset bytes
      8'h10, 8'h7F,                 // no length bytes
      8'h09, 8'h90, 8'hFF,          // oversized nibbles
      8'h48, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'h00, 8'h00, 8'h00, 8'h80,   // full length, four-byte negative delta
      8'h00                         // end clears the cluster base
    };
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 87; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 87; end
        default: begin send_idle_pct = 15; stall_pct = 15; end
      endcase
      target = bytes_sent + PhaseBytes;
      while (bytes_sent < target) send_random_entry();
      wait_drained();
    end

    repeat (TailCycles) @(posedge clk);
    if (tracker.leftover_check() == 0) begin
      $display("data_run_list_decoder_tb: PASS");
    end else begin
      $display("data_run_list_decoder_tb: FAIL");
    end
    $finish;
  end

endmodule
